/* rtl/bpgb_pkg.sv */
// Package for the box pixel border/gradient/blend engine.
// Holds the request types, the register map, the channel helpers and the pipeline item.
// No dependencies.
package bpgb_pkg;

    localparam int unsigned DIM_W      = 11;
    localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;
    localparam int unsigned CH_W       = 6;
    localparam int unsigned NUM_W      = 16;
    localparam int unsigned NUM_CELLS  = 6;
    localparam int unsigned NUM_CH     = 3;
    localparam int unsigned BLEND_W    = 14;
    localparam logic [16:0] DIV255_MAGIC = 17'h8081;

    localparam logic [2:0] CFG_FILL_COLOR   = 3'd0;
    localparam logic [2:0] CFG_END_COLOR    = 3'd1;
    localparam logic [2:0] CFG_BORDER_COLOR = 3'd2;
    localparam logic [2:0] CFG_ALPHA        = 3'd3;
    localparam logic [2:0] CFG_BORDER_WIDTH = 3'd4;
    localparam logic [2:0] CFG_FILL_MODE    = 3'd5;
    localparam logic [2:0] CFG_AREA_WIDTH   = 3'd6;
    localparam logic [2:0] CFG_AREA_HEIGHT  = 3'd7;

    localparam logic [1:0] MODE_SOLID  = 2'd0;
    localparam logic [1:0] MODE_GRAD_Y = 2'd1;
    localparam logic [1:0] MODE_GRAD_X = 2'd2;
    // spare code, behaves as a gradient along x
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    typedef struct packed {
        logic [9:0]  x_offset;
        logic [9:0]  y_offset;
        logic [15:0] back_pixel;
    } in_req_t;

    typedef struct packed {
        logic [15:0] pixel_out;
        logic        in_border;
    } out_req_t;

    typedef struct packed {
        logic [15:0]      fill_color;
        logic [15:0]      end_color;
        logic [15:0]      border_color;
        logic [7:0]       alpha;
        logic [DIM_W-1:0] border_width;
        logic [1:0]       fill_mode;
        logic [DIM_W-1:0] area_width;
        logic [DIM_W-1:0] area_height;
    } cfg_t;

    // one pixel travelling along the divider row
    typedef struct packed {
        logic                             border;
        logic [15:0]                      back;
        logic [DIM_W-1:0]                 dsor;
        logic [NUM_CH-1:0][NUM_W-1:0]     rem;
        logic [NUM_CH-1:0][CH_W-1:0]      quo;
    } div_item_t;

    function automatic logic [DIM_W-1:0] fit_size(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > MAX_DIM)
            r = MAX_DIM;
        else
            r = v;
        return r;
    endfunction

    // channel 0 red, 1 green, 2 blue; red and blue zero-extended
    function automatic logic [CH_W-1:0] get_ch(input logic [15:0] c, input logic [1:0] i);
        logic [CH_W-1:0] r;
        case (i)
            2'd0:    r = {1'b0, c[15:11]};
            2'd1:    r = c[10:5];
            default: r = {1'b0, c[4:0]};
        endcase
        return r;
    endfunction

endpackage

/* rtl/bpgb_front.sv */
// Front stage: clamps the position, finds the border band and forms the gradient numerators.
// Depends on bpgb_pkg.
module bpgb_front
    import bpgb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  in_req_t   in_data,
    input  cfg_t      cfg,
    output logic      valid,
    output div_item_t item
);

    logic             valid_reg;
    div_item_t        item_reg;
    div_item_t        item_next;
    logic [DIM_W-1:0] w_fit;
    logic [DIM_W-1:0] h_fit;
    logic [DIM_W-1:0] x_c;
    logic [DIM_W-1:0] y_c;
    logic [DIM_W-1:0] pos;
    logic [DIM_W-1:0] pos_end;
    logic [DIM_W-1:0] bw;
    logic             grad_y;
    logic [16:0]      prod_a [NUM_CH];
    logic [16:0]      prod_b [NUM_CH];

    always_comb
    begin
        w_fit = fit_size(cfg.area_width);
        h_fit = fit_size(cfg.area_height);
        x_c = ({1'b0, in_data.x_offset} >= w_fit) ? w_fit - DIM_W'(1) : {1'b0, in_data.x_offset};
        y_c = ({1'b0, in_data.y_offset} >= h_fit) ? h_fit - DIM_W'(1) : {1'b0, in_data.y_offset};
        bw = cfg.border_width;
        grad_y = (cfg.fill_mode == MODE_GRAD_Y);
        pos = grad_y ? y_c : x_c;
        item_next.dsor = grad_y ? h_fit : w_fit;
        pos_end = item_next.dsor - pos;
        item_next.border = (bw != '0) &&
                           ((x_c < bw) || (y_c < bw) ||
                            (({1'b0, x_c} + {1'b0, bw}) >= {1'b0, w_fit}) ||
                            (({1'b0, y_c} + {1'b0, bw}) >= {1'b0, h_fit}));
        item_next.back = in_data.back_pixel;
        for (int i = 0; i < NUM_CH; i++)
        begin
            prod_a[i] = 17'(get_ch(cfg.fill_color, 2'(i))) * 17'(pos);
            prod_b[i] = 17'(get_ch(cfg.end_color, 2'(i))) * 17'(pos_end);
            item_next.rem[i] = NUM_W'(prod_a[i] + prod_b[i]);
            item_next.quo[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

/* rtl/bpgb_cell.sv */
// One divider cell: settles one quotient bit of all three channels and hands on the pixel.
// Depends on bpgb_pkg.
module bpgb_cell
    import bpgb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic [2:0] shift,
    input  logic      valid_in,
    input  div_item_t item_in,
    output logic      valid,
    output div_item_t item
);

    logic        valid_reg;
    div_item_t   item_reg;
    div_item_t   item_next;
    logic [16:0] trial;
    logic        ge;

    always_comb
    begin
        item_next = item_in;
        trial = 17'(item_in.dsor) << shift;
        for (int i = 0; i < NUM_CH; i++)
        begin
            ge = ({1'b0, item_in.rem[i]} >= trial);
            if (ge)
                item_next.rem[i] = NUM_W'({1'b0, item_in.rem[i]} - trial);
            item_next.quo[i] = {item_in.quo[i][CH_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

/* rtl/bpgb_blend.sv */
// Color select and alpha blend: two registered stages, the second is the output register.
// Depends on bpgb_pkg.
module bpgb_blend
    import bpgb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      valid_in,
    input  div_item_t item_in,
    input  cfg_t      cfg,
    output logic      valid,
    output out_req_t  result
);

    logic                          mid_valid_reg;
    logic                          mid_border_reg;
    logic [NUM_CH-1:0][BLEND_W-1:0] mid_sum_reg;
    logic [NUM_CH-1:0][BLEND_W-1:0] mid_sum_next;
    logic                          out_valid_reg;
    out_req_t                      out_reg;
    out_req_t                      out_next;
    logic [CH_W-1:0]               col [NUM_CH];
    logic [CH_W-1:0]               bk  [NUM_CH];
    logic [7:0]                    alpha_n;
    logic [30:0]                   prod [NUM_CH];
    logic [CH_W-1:0]               q [NUM_CH];

    always_comb
    begin
        alpha_n = 8'd255 - cfg.alpha;
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (item_in.border)
                col[i] = get_ch(cfg.border_color, 2'(i));
            else if (cfg.fill_mode == MODE_SOLID)
                col[i] = get_ch(cfg.fill_color, 2'(i));
            else
                col[i] = item_in.quo[i];
            bk[i] = get_ch(item_in.back, 2'(i));
            mid_sum_next[i] = BLEND_W'(BLEND_W'(col[i]) * BLEND_W'(cfg.alpha) +
                                       BLEND_W'(bk[i]) * BLEND_W'(alpha_n));
        end
    end

    // divide by 255 through the reciprocal, exact for 16-bit sums
    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            prod[i] = 31'(mid_sum_reg[i]) * 31'(DIV255_MAGIC);
            q[i] = prod[i][28:23];
        end
        out_next.pixel_out = {q[0][4:0], q[1], q[2][4:0]};
        out_next.in_border = mid_border_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mid_valid_reg <= valid_in;
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid_border_reg <= item_in.border;
            mid_sum_reg    <= mid_sum_next;
            out_reg        <= out_next;
        end
    end

    assign valid  = out_valid_reg;
    assign result = out_reg;

endmodule

/* rtl/box_pixel_border_gradient_blend.sv */
// Top level of the RGB565 box pixel engine: border band, gradient fill, alpha blend.
// Depends on bpgb_pkg, bpgb_front, bpgb_cell and bpgb_blend.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | input     | in_valid/in_stall  | in_data (x_offset, y_offset, back_pixel)
//  out     | output    | out_valid/out_stall| out_data (pixel_out, in_border)
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One request enters per clock while the output is not stalled; each passes from accept to out_valid through the
// front stage, six divider cells (one quotient bit each), blend stage and output register.
// Reset (rst_n, async, low) clears all valid bits and loads the register reset values.
// A stalled output freezes the whole row; in_stall follows out_valid & out_stall.
module box_pixel_border_gradient_blend
    import bpgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_req_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_req_t    out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      en;
    logic      front_valid;
    div_item_t front_item;
    logic      cell_valid [NUM_CELLS];
    div_item_t cell_item  [NUM_CELLS];
    logic [NUM_CELLS-1:0] cell_valid_vec;

    // advance the whole row unless a finished result is held at the output
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fill_color   <= '0;
            cfg_reg.end_color    <= '0;
            cfg_reg.border_color <= '0;
            cfg_reg.alpha        <= 8'd255;
            cfg_reg.border_width <= '0;
            cfg_reg.fill_mode    <= MODE_SOLID;
            cfg_reg.area_width   <= DIM_W'(1);
            cfg_reg.area_height  <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FILL_COLOR:   cfg_reg.fill_color   <= cfg_data;
                CFG_END_COLOR:    cfg_reg.end_color    <= cfg_data;
                CFG_BORDER_COLOR: cfg_reg.border_color <= cfg_data;
                CFG_ALPHA:        cfg_reg.alpha        <= cfg_data[7:0];
                CFG_BORDER_WIDTH: cfg_reg.border_width <= cfg_data[DIM_W-1:0];
                CFG_FILL_MODE:    cfg_reg.fill_mode    <= cfg_data[1:0];
                CFG_AREA_WIDTH:   cfg_reg.area_width   <= cfg_data[DIM_W-1:0];
                CFG_AREA_HEIGHT:  cfg_reg.area_height  <= cfg_data[DIM_W-1:0];
                default:          cfg_reg.fill_color   <= cfg_reg.fill_color;
            endcase
        end
    end

    // clamp, border test and gradient numerators
    bpgb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .valid    (front_valid),
        .item     (front_item)
    );

    // divider row: cell k settles quotient bit 5-k
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        bpgb_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .shift    (3'(NUM_CELLS - 1 - k)),
            .valid_in ((k == 0) ? front_valid : cell_valid[(k == 0) ? 0 : k-1]),
            .item_in  ((k == 0) ? front_item  : cell_item[(k == 0) ? 0 : k-1]),
            .valid    (cell_valid[k]),
            .item     (cell_item[k])
        );
        assign cell_valid_vec[k] = cell_valid[k];
    end

    // color select, blend with the background and output register
    bpgb_blend u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid_in (cell_valid[NUM_CELLS-1]),
        .item_in  (cell_item[NUM_CELLS-1]),
        .cfg      (cfg_reg),
        .valid    (out_valid),
        .result   (out_data)
    );

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result held");

    a_front_to_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (en && front_valid) |=> cell_valid_vec[0])
        else $error("request lost between front stage and first cell");

    a_row_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(cell_valid_vec))
        else $error("divider row moved while stalled");

endmodule
